@@ hdl/ispd_pkg.sv @@
// Shared types, constants and helpers for the inverse Park / SVPWM duty pipeline.
package ispd_pkg;

  // Sine table depth per electrical turn.
  localparam int SINE_ENTRIES = 256;

  // Quarter-wave polynomial coefficients for the sine table, Q15 domain.
  localparam longint POLY_A = 51472;
  localparam longint POLY_B = 21024;
  localparam longint POLY_C = 2320;

  // sqrt(3)/2 in Q1.15.
  localparam logic signed [15:0] HALF_SQRT3 = 16'sd28378;

  // Configuration register indexes and reset values.
  localparam logic CFG_PWM_PERIOD = 1'b0;
  localparam logic CFG_DUTY_SCALE = 1'b1;
  localparam logic [15:0] PERIOD_RESET = 16'd4000;
  localparam logic [31:0] SCALE_RESET  = 32'd18919980;

  // Internal widths.
  localparam int AB_W  = 25;  // alpha, beta in Q.15 volts
  localparam int YZ_W  = 27;  // Y and Z reference voltages in Q.15 volts
  localparam int PR_W  = 60;  // voltage times counts-per-volt product
  localparam int XYZ_W = 46;  // X, Y, Z in Q.16 counts
  localparam int T_W   = 47;  // active times, one negation wider
  localparam int D_W   = 49;  // compare values in Q.16 counts

  // Cycles from an accepted command to its result strobe.
  localparam int LATENCY = 11;

  // Sector numbers.
  localparam logic [2:0] SEC_ZERO = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;

  typedef struct packed {
    logic signed [15:0] uq;
    logic signed [15:0] ud;
    logic        [15:0] angle;
  } cmd_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector;
  } result_t;

  // Rotated voltages handed from the transform to the duty stages.
  typedef struct packed {
    logic signed [AB_W-1:0] beta;
    logic signed [YZ_W-1:0] yv;
    logic signed [YZ_W-1:0] zv;
  } volt_t;

  // Map the sign code {-Y>0, -Z>0, X>0} to a sector; codes 0 and 7 map to the zero vector.
  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] sec;
    unique case (code)
      3'd1:    sec = SEC_2;
      3'd2:    sec = SEC_6;
      3'd3:    sec = SEC_1;
      3'd4:    sec = SEC_4;
      3'd5:    sec = SEC_3;
      3'd6:    sec = SEC_5;
      default: sec = SEC_ZERO;
    endcase
    return sec;
  endfunction

endpackage

@@ hdl/inverse_park_svpwm_duty.sv @@
// Top level: inverse Park transform and space-vector PWM compare value pipeline.
//
//   channel   signals                          transfer
//   command   start, busy, cmd_i               start high and busy low at a clock edge
//   result    done_o, result_o                 one-cycle strobe, always taken
//   config    cfg_we_i, cfg_idx_i, cfg_data_i  write enable at a clock edge
//
// A command is taken every cycle while busy is low; the delay to its result strobe is
// set by the table read, the three multiplier stages and the adder stages behind them.
// busy is high only during reset and the first cycle after it.
// Reset clears the valid bits and loads the period and scale defaults.
// The result side has no stall, so the pipeline never holds.
module inverse_park_svpwm_duty #(
  parameter int SineEntries = ispd_pkg::SINE_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ispd_pkg::cmd_t    cmd_i,
  output logic              done_o,
  output ispd_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);

  logic [15:0]        period_q;
  logic [31:0]        scale_q;
  logic               busy_q;
  logic               v1_q;
  logic signed [15:0] uq_q, ud_q;
  logic signed [15:0] sin_s, cos_s;
  logic               rot_vld;
  ispd_pkg::volt_t    volt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= ispd_pkg::PERIOD_RESET;
      scale_q  <= ispd_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ispd_pkg::CFG_PWM_PERIOD: period_q <= cfg_data_i[15:0];
        ispd_pkg::CFG_DUTY_SCALE: scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      v1_q   <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      v1_q   <= start & ~busy_q;
    end
  end

  // hold the voltages beside the table read
  always_ff @(posedge clk_i) begin
    uq_q <= cmd_i.uq;
    ud_q <= cmd_i.ud;
  end

  ispd_sine_rom #(
    .Entries (SineEntries)
  ) u_rom (
    .clk_i   (clk_i),
    .angle_i (cmd_i.angle),
    .sin_o   (sin_s),
    .cos_o   (cos_s)
  );

  ispd_rotate u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .uq_i    (uq_q),
    .ud_i    (ud_q),
    .sin_i   (sin_s),
    .cos_i   (cos_s),
    .valid_o (rot_vld),
    .volt_o  (volt)
  );

  ispd_duty u_duty (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rot_vld),
    .volt_i   (volt),
    .period_i (period_q),
    .scale_i  (scale_q),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  assign busy = busy_q;

endmodule

@@ hdl/ispd_sine_rom.sv @@
// Sine/cosine lookup table with two registered read ports addressed by the angle.
module ispd_sine_rom #(
  parameter int Entries = ispd_pkg::SINE_ENTRIES
) (
  input  logic               clk_i,
  input  logic [15:0]        angle_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  localparam int IdxW = $clog2(Entries);
  localparam logic [IdxW:0] EntW   = (IdxW+1)'(Entries);
  localparam logic [IdxW:0] QuartW = (IdxW+1)'(Entries / 4);

  typedef logic signed [15:0] tab_t [Entries];

  function automatic tab_t build_table();
    tab_t   tab;
    longint p, q, r, x, x2, t, s;
    for (int i = 0; i < Entries; i++) begin
      p = ((longint'(i) * 65536) / Entries) & 65535;
      q = p >> 14;
      r = p & 16383;
      x = q[0] ? (32768 - (r << 1)) : (r << 1);
      x2 = (x * x) >> 15;
      t = ispd_pkg::POLY_B - ((ispd_pkg::POLY_C * x2) >> 15);
      t = ispd_pkg::POLY_A - ((t * x2) >> 15);
      s = (x * t) >> 15;
      if (s > 32767) s = 32767;
      tab[i] = (q >= 2) ? 16'(-s) : 16'(s);
    end
    return tab;
  endfunction

  localparam tab_t SineTab = build_table();

  logic [16+IdxW-1:0] scaled;
  logic [IdxW-1:0]    sin_idx;
  logic [IdxW:0]      cos_sum;
  logic [IdxW-1:0]    cos_idx;

  always_comb begin
    scaled  = (16+IdxW)'(angle_i) * (16+IdxW)'(Entries);
    sin_idx = scaled[16+IdxW-1:16];
    cos_sum = {1'b0, sin_idx} + QuartW;
    // wrap past a full turn
    if (cos_sum >= EntW) begin
      cos_sum = cos_sum - EntW;
    end
    cos_idx = cos_sum[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    sin_o <= SineTab[sin_idx];
    cos_o <= SineTab[cos_idx];
  end

endmodule

@@ hdl/ispd_rotate.sv @@
// Inverse Park rotation and Y/Z reference voltages, four register stages.
module ispd_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [15:0]  uq_i,
  input  logic signed [15:0]  ud_i,
  input  logic signed [15:0]  sin_i,
  input  logic signed [15:0]  cos_i,
  output logic                valid_o,
  output ispd_pkg::volt_t     volt_o
);

  localparam int AbW = ispd_pkg::AB_W;
  localparam int YzW = ispd_pkg::YZ_W;

  logic [3:0] vld_q;

  // stage 2: products
  logic signed [31:0] us_q, dc_q, uc_q, ds_q;
  // stage 3: alpha, beta
  logic signed [AbW-1:0] alpha_q, beta3_q;
  logic signed [33:0]    alpha_sum, beta_sum;
  // stage 4: alpha * sqrt3/2
  logic signed [40:0]    ma_q;
  logic signed [AbW-1:0] beta4_q;
  // stage 5: Y, Z
  logic signed [41:0]    bq, y_sum, z_sum;
  logic signed [YzW-1:0] yv_q, zv_q;
  logic signed [AbW-1:0] beta5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    us_q <= 32'(uq_i) * 32'(sin_i);
    dc_q <= 32'(ud_i) * 32'(cos_i);
    uc_q <= 32'(uq_i) * 32'(cos_i);
    ds_q <= 32'(ud_i) * 32'(sin_i);
  end

  always_comb begin
    alpha_sum = 34'(dc_q) - 34'(us_q) + 34'sd128;
    beta_sum  = 34'(uc_q) + 34'(ds_q) + 34'sd128;
  end

  always_ff @(posedge clk_i) begin
    alpha_q <= AbW'(alpha_sum >>> 8);
    beta3_q <= AbW'(beta_sum >>> 8);
  end

  always_ff @(posedge clk_i) begin
    ma_q    <= 41'(alpha_q) * 41'(ispd_pkg::HALF_SQRT3);
    beta4_q <= beta3_q;
  end

  always_comb begin
    bq    = 42'(beta4_q) <<< 14;
    y_sum = bq + 42'(ma_q) + 42'sd16384;
    z_sum = bq - 42'(ma_q) + 42'sd16384;
  end

  always_ff @(posedge clk_i) begin
    yv_q    <= YzW'(y_sum >>> 15);
    zv_q    <= YzW'(z_sum >>> 15);
    beta5_q <= beta4_q;
  end

  assign valid_o     = vld_q[3];
  assign volt_o.beta = beta5_q;
  assign volt_o.yv   = yv_q;
  assign volt_o.zv   = zv_q;

endmodule

@@ hdl/ispd_duty.sv @@
// Counts scaling, sector decode, active times and saturated compare values, six stages.
module ispd_duty (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ispd_pkg::volt_t    volt_i,
  input  logic [15:0]        period_i,
  input  logic [31:0]        scale_i,
  output logic               valid_o,
  output ispd_pkg::result_t  result_o
);

  localparam int PrW = ispd_pkg::PR_W;
  localparam int XW  = ispd_pkg::XYZ_W;
  localparam int TW  = ispd_pkg::T_W;
  localparam int DW  = ispd_pkg::D_W;

  logic [5:0] vld_q;

  // stage 6
  logic signed [32:0]    k_s;
  logic signed [PrW-1:0] px_q, py_q, pz_q;
  // stage 7
  logic signed [PrW-1:0] rx, ry, rz;
  logic signed [XW-1:0]  x_d, y_d, z_d;
  logic signed [XW-1:0]  x_q, y_q, z_q;
  logic [2:0]            sec7_q;
  // stage 8
  logic signed [TW-1:0]  t1_d, t2_d, t1_q, t2_q;
  logic [2:0]            sec8_q;
  // stage 9
  logic signed [DW-1:0]  diff;
  logic signed [DW-1:0]  first9_q, t1_9_q, tsum_q;
  logic [2:0]            sec9_q;
  // stage 10
  logic signed [DW-1:0]  first_q, second_q, third_q;
  logic [2:0]            sec10_q;
  // stage 11
  logic signed [DW-1:0]  da, db, dc;
  ispd_pkg::result_t     res_d, res_q;

  function automatic logic [15:0] sat_duty(input logic signed [DW-1:0] d,
                                           input logic [15:0] period);
    logic signed [DW-17:0] v;
    v = (DW-16)'(d >>> 16);
    if (v < 0) begin
      return 16'd0;
    end else if (v > (DW-16)'(period)) begin
      return period;
    end
    return v[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign k_s = {1'b0, scale_i};

  always_ff @(posedge clk_i) begin
    px_q <= PrW'(volt_i.beta) * PrW'(k_s);
    py_q <= PrW'(volt_i.yv) * PrW'(k_s);
    pz_q <= PrW'(volt_i.zv) * PrW'(k_s);
  end

  always_comb begin
    rx  = px_q + PrW'(16384);
    ry  = py_q + PrW'(16384);
    rz  = pz_q + PrW'(16384);
    x_d = XW'(rx >>> 15);
    y_d = XW'(ry >>> 15);
    z_d = XW'(rz >>> 15);
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    sec7_q <= ispd_pkg::sector_of_code({y_d < 0, z_d < 0, x_d > 0});
  end

  always_comb begin
    unique case (sec7_q)
      ispd_pkg::SEC_1: begin t1_d = -TW'(z_q); t2_d =  TW'(x_q); end
      ispd_pkg::SEC_2: begin t1_d =  TW'(z_q); t2_d =  TW'(y_q); end
      ispd_pkg::SEC_3: begin t1_d =  TW'(x_q); t2_d = -TW'(y_q); end
      ispd_pkg::SEC_4: begin t1_d = -TW'(x_q); t2_d =  TW'(z_q); end
      ispd_pkg::SEC_5: begin t1_d = -TW'(y_q); t2_d = -TW'(z_q); end
      ispd_pkg::SEC_6: begin t1_d =  TW'(y_q); t2_d = -TW'(x_q); end
      default:         begin t1_d = '0;        t2_d = '0;        end
    endcase
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    sec8_q <= sec7_q;
  end

  // center the zero vector time: (P*2^16 - t1 - t2) / 2, floored
  assign diff = $signed({1'b0, period_i, 16'd0, {(DW-33){1'b0}}} >> (DW-33))
                - DW'(t1_q) - DW'(t2_q);

  always_ff @(posedge clk_i) begin
    first9_q <= diff >>> 1;
    t1_9_q   <= DW'(t1_q);
    tsum_q   <= DW'(t1_q) + DW'(t2_q);
    sec9_q   <= sec8_q;
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first9_q;
    second_q <= first9_q + t1_9_q;
    third_q  <= first9_q + tsum_q;
    sec10_q  <= sec9_q;
  end

  always_comb begin
    unique case (sec10_q)
      ispd_pkg::SEC_1: begin da = first_q;  db = second_q; dc = third_q;  end
      ispd_pkg::SEC_2: begin da = second_q; db = first_q;  dc = third_q;  end
      ispd_pkg::SEC_3: begin da = third_q;  db = first_q;  dc = second_q; end
      ispd_pkg::SEC_4: begin da = third_q;  db = second_q; dc = first_q;  end
      ispd_pkg::SEC_5: begin da = second_q; db = third_q;  dc = first_q;  end
      default:         begin da = first_q;  db = third_q;  dc = second_q; end
    endcase
    if (sec10_q == ispd_pkg::SEC_ZERO) begin
      res_d.duty_a = {1'b0, period_i[15:1]};
      res_d.duty_b = {1'b0, period_i[15:1]};
      res_d.duty_c = {1'b0, period_i[15:1]};
    end else begin
      res_d.duty_a = sat_duty(da, period_i);
      res_d.duty_b = sat_duty(db, period_i);
      res_d.duty_c = sat_duty(dc, period_i);
    end
    res_d.sector = sec10_q;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = vld_q[5];
  assign result_o = res_q;

endmodule

@@ hdl/ispd_checker.sv @@
// Port-level checks for the duty pipeline, bound to the top level.
module ispd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input ispd_pkg::result_t result_o
);

  a_beat_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##11 done_o)
    else $error("accepted beat did not strobe a result after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##11 !done_o)
    else $error("result strobe without an accepted beat");

  a_zero_vector : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.sector == ispd_pkg::SEC_ZERO) |->
      (result_o.duty_a == result_o.duty_b && result_o.duty_b == result_o.duty_c))
    else $error("zero vector with unequal duties");

  a_sector_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.sector != 3'd7))
    else $error("sector out of range");

endmodule

bind inverse_park_svpwm_duty ispd_checker u_ispd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

@@ bench/inverse_park_svpwm_duty_test.sv @@
// Self-checking bench for the inverse Park / SVPWM duty pipeline.
`timescale 1ns / 100ps

module inverse_park_svpwm_duty_test;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 7;
  localparam int PHASE_BEATS = 172;

  class duty_scoreboard;
    logic [15:0]       pwm_period;
    logic [31:0]       duty_scale;
    ispd_pkg::result_t expected_duties[$];
    int                errors;
    int                checked;
    int                sector_hits[7];

    function new();
      pwm_period = ispd_pkg::PERIOD_RESET;
      duty_scale = ispd_pkg::SCALE_RESET;
      errors     = 0;
      checked    = 0;
      foreach (sector_hits[i]) sector_hits[i] = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == ispd_pkg::CFG_PWM_PERIOD) pwm_period = data[15:0];
      else duty_scale = data;
    endfunction

    static function longint round_q(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Quarter-wave polynomial sine, mirrored and signed by quadrant.
    static function longint table_sine(longint i);
      longint p, q, r, x, x2, t, s;
      p  = ((i * 65536) / ispd_pkg::SINE_ENTRIES) & 64'hFFFF;
      q  = p >> 14;
      r  = p & 64'h3FFF;
      x  = q[0] ? 32768 - (r << 1) : (r << 1);
      x2 = (x * x) >>> 15;
      t  = ispd_pkg::POLY_B - ((ispd_pkg::POLY_C * x2) >>> 15);
      t  = ispd_pkg::POLY_A - ((t * x2) >>> 15);
      s  = (x * t) >>> 15;
      if (s > 32767) s = 32767;
      return (q >= 2) ? -s : s;
    endfunction

    static function logic [2:0] sector_from_signs(logic [2:0] code);
      case (code)
        3'd1:    return ispd_pkg::SEC_2;
        3'd2:    return ispd_pkg::SEC_6;
        3'd3:    return ispd_pkg::SEC_1;
        3'd4:    return ispd_pkg::SEC_4;
        3'd5:    return ispd_pkg::SEC_3;
        3'd6:    return ispd_pkg::SEC_5;
        default: return ispd_pkg::SEC_ZERO;
      endcase
    endfunction

    function longint clamp_duty(longint q16);
      longint v;
      v = q16 >>> 16;
      if (v < 0) v = 0;
      if (v > longint'(pwm_period)) v = pwm_period;
      return v;
    endfunction

    function ispd_pkg::result_t predict_duties(ispd_pkg::cmd_t c);
      longint            uq, ud, idx, cidx, sn, cs, alpha, beta, yv, zv, h3, k;
      longint            x, y, z, t1, t2, d0, d1, d2, dx, dy, dz;
      logic [2:0]        code, sec;
      ispd_pkg::result_t r;
      uq    = c.uq;
      ud    = c.ud;
      h3    = ispd_pkg::HALF_SQRT3;
      k     = duty_scale;
      idx   = (longint'(c.angle) * ispd_pkg::SINE_ENTRIES) >> 16;
      cidx  = (idx + ispd_pkg::SINE_ENTRIES / 4) % ispd_pkg::SINE_ENTRIES;
      idx   = idx % ispd_pkg::SINE_ENTRIES;
      sn    = table_sine(idx);
      cs    = table_sine(cidx);
      alpha = round_q(-uq * sn + ud * cs, 8);
      beta  = round_q(uq * cs + ud * sn, 8);
      yv    = round_q(alpha * h3 + beta * 16384, 15);
      zv    = round_q(-alpha * h3 + beta * 16384, 15);
      x     = round_q(beta * k, 15);
      y     = round_q(yv * k, 15);
      z     = round_q(zv * k, 15);
      code  = {y < 0, z < 0, x > 0};
      sec   = sector_from_signs(code);
      r.sector = sec;
      if (sec == ispd_pkg::SEC_ZERO) begin
        r.duty_a = pwm_period >> 1;
        r.duty_b = pwm_period >> 1;
        r.duty_c = pwm_period >> 1;
        return r;
      end
      case (sec)
        ispd_pkg::SEC_1: begin t1 = -z; t2 = x;  end
        ispd_pkg::SEC_2: begin t1 = z;  t2 = y;  end
        ispd_pkg::SEC_3: begin t1 = x;  t2 = -y; end
        ispd_pkg::SEC_4: begin t1 = -x; t2 = z;  end
        ispd_pkg::SEC_5: begin t1 = -y; t2 = -z; end
        default:         begin t1 = y;  t2 = -x; end
      endcase
      d0 = ((longint'(pwm_period) * 65536) - t1 - t2) >>> 1;
      d1 = d0 + t1;
      d2 = d1 + t2;
      // Route lowest/middle/highest compare to the phases of this sector.
      case (sec)
        ispd_pkg::SEC_1: begin dx = d0; dy = d1; dz = d2; end
        ispd_pkg::SEC_2: begin dy = d0; dx = d1; dz = d2; end
        ispd_pkg::SEC_3: begin dy = d0; dz = d1; dx = d2; end
        ispd_pkg::SEC_4: begin dz = d0; dy = d1; dx = d2; end
        ispd_pkg::SEC_5: begin dz = d0; dx = d1; dy = d2; end
        default:         begin dx = d0; dz = d1; dy = d2; end
      endcase
      r.duty_a = 16'(clamp_duty(dx));
      r.duty_b = 16'(clamp_duty(dy));
      r.duty_c = 16'(clamp_duty(dz));
      return r;
    endfunction

    function void note_command(ispd_pkg::cmd_t c);
      expected_duties.push_back(predict_duties(c));
    endfunction

    function void report(string what, ispd_pkg::result_t exp_r, ispd_pkg::result_t got);
      errors++;
      if (errors <= 10)
        $display("%0t: %s exp a=%0d b=%0d c=%0d sec=%0d got a=%0d b=%0d c=%0d sec=%0d",
                 $time, what, exp_r.duty_a, exp_r.duty_b, exp_r.duty_c, exp_r.sector,
                 got.duty_a, got.duty_b, got.duty_c, got.sector);
    endfunction

    function void check_result(ispd_pkg::result_t got);
      ispd_pkg::result_t exp_r;
      if (expected_duties.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      exp_r = expected_duties.pop_front();
      checked++;
      if (got.sector <= 3'd6) sector_hits[got.sector]++;
      if (got.duty_a != exp_r.duty_a || got.duty_b != exp_r.duty_b ||
          got.duty_c != exp_r.duty_c || got.sector != exp_r.sector)
        report("mismatch", exp_r, got);
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  ispd_pkg::cmd_t    cmd_i = '0;
  logic              done_o;
  ispd_pkg::result_t result_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = ispd_pkg::CFG_PWM_PERIOD;
  logic [31:0]       cfg_data_i = '0;

  duty_scoreboard sb;
  int idle_pct;
  int beats_sent;
  int quiet_cycles;
  int settings_run;

  inverse_park_svpwm_duty i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Track every accepted beat and run the quiet-cycle watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (start && !busy) sb.note_command(cmd_i);
      if (done_o) sb.check_result(result_o);
      if (cfg_we_i || (start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("** inverse_park_svpwm_duty: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_cmd(ispd_pkg::cmd_t c);
    int gap;
    gap = 0;
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    beats_sent++;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and hold until every predicted result has been seen.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] period_word, logic [31:0] scale_word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ispd_pkg::CFG_PWM_PERIOD;
    cfg_data_i <= period_word;
    @(posedge clk_i);
    cfg_idx_i  <= ispd_pkg::CFG_DUTY_SCALE;
    cfg_data_i <= scale_word;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_run++;
  endtask

  function automatic ispd_pkg::cmd_t make_cmd(int signed uq, int signed ud, int unsigned ang);
    ispd_pkg::cmd_t c;
    c.uq    = 16'(uq);
    c.ud    = 16'(ud);
    c.angle = 16'(ang);
    return c;
  endfunction

  function automatic ispd_pkg::cmd_t random_cmd();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5)
      return make_cmd($urandom, $urandom, $urandom);
    else if (kind <= 7)
      return make_cmd($urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256, $urandom);
    else if (kind == 8)
      // Land close to a sector boundary.
      return make_cmd($urandom_range(0, 8191) - 4096, ($urandom_range(0, 1) != 0) ? 0 : 200,
                      ($urandom_range(0, 5) * 65536 / 6 + $urandom_range(0, 64) + 65504));
    else if ($urandom_range(0, 1) != 0)
      return make_cmd($urandom, 0, $urandom);
    else
      return make_cmd(0, $urandom, $urandom);
  endfunction

  initial begin
    logic [31:0] period_word, scale_word;
    sb = new();
    idle_pct     = 25;
    beats_sent   = 0;
    quiet_cycles = 0;
    settings_run = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at reset settings.
    send_cmd(make_cmd(0, 0, 0));
    send_cmd(make_cmd(32767, 0, 0));
    send_cmd(make_cmd(32767, 0, 16384));
    send_cmd(make_cmd(32767, 0, 32768));
    send_cmd(make_cmd(32767, 0, 49152));
    send_cmd(make_cmd(32767, 0, 65535));
    send_cmd(make_cmd(-32768, -32768, 32768));
    send_cmd(make_cmd(-32768, 32767, 10922));
    for (int i = 0; i < 12; i++) send_cmd(make_cmd(1000, -300, i * 5461 + 2730));
    send_cmd(make_cmd(1, 0, 12345));
    send_cmd(make_cmd(32767, 32767, 65535));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin period_word = {16'($urandom), 16'd4000}; scale_word = 32'd18919980; end
        1: begin period_word = 32'd1; scale_word = $urandom_range(1 << 16, 1 << 28); end
        2: begin period_word = 32'd65535; scale_word = 32'hFFFF_FFFF; end
        3: begin period_word = 32'd0; scale_word = $urandom_range(1 << 20, 1 << 26); end
        4: begin period_word = 32'hFFFF_FFFF; scale_word = 32'd0; end
        5: begin
          period_word = $urandom_range(100, 20000);
          scale_word  = $urandom_range(1 << 18, 1 << 26);
        end
        default: begin period_word = $urandom; scale_word = $urandom; end
      endcase
      set_regs(period_word, scale_word);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        idle_pct = (beats_sent < 420) ? 25 : (beats_sent < 820) ? 52 : 0;
        send_cmd(random_cmd());
        if ($urandom_range(0, 149) == 0) drain();
      end
      drain();
    end

    drain();
    repeat (ispd_pkg::LATENCY + 4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
      sb.errors += sb.pending();
    end
    $display("Sent %0d commands, checked %0d results under %0d register settings.",
             beats_sent, sb.checked, settings_run);
    $display("Sector hits 0..6: %0d %0d %0d %0d %0d %0d %0d; mismatches: %0d",
             sb.sector_hits[0], sb.sector_hits[1], sb.sector_hits[2], sb.sector_hits[3],
             sb.sector_hits[4], sb.sector_hits[5], sb.sector_hits[6], sb.errors);
    if (sb.errors == 0) begin
      $display("** inverse_park_svpwm_duty: PASSED **");
    end else begin
      $display("** inverse_park_svpwm_duty: FAILED **");
    end
    $finish;
  end

endmodule
